### rtl/core/drrip_pkg.sv
// Shared command and status types for the DRRIP tag cache core.
package drrip_pkg;

    // Controller to datapath commands
    typedef struct packed {
        logic clr;   // zero one set row of the stores
        logic load;  // capture the request word and read its set
        logic exec;  // update the set and register the result word
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;  // the clearing pass is at its last row
    } t_status;

endpackage

### rtl/core/drrip_ctrl.sv
// Sequencer for the DRRIP tag cache: clearing pass, request accept, set update.
module drrip_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  drrip_pkg::t_status i_status,
    output drrip_pkg::t_cmd    o_cmd
);
    import drrip_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Advance the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Pick the next state and drive the commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        busy       = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A load is always followed by exactly one update
    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("load not followed by update");
    // No request is taken during the clearing pass
    a_no_load_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr |-> !o_cmd.load && busy)
        else $error("request taken while clearing");
    // An update never runs twice in a row
    a_exec_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> !o_cmd.exec)
        else $error("back to back update");
`endif

endmodule

### rtl/core/drrip_dp.sv
// Datapath for the DRRIP tag cache: set stores, victim choice, duel counters.
module drrip_dp #(
    parameter int SET_BITS  = 7,
    parameter int WAYS      = 8,
    parameter int TAG_WIDTH = 32,
    parameter int CORES     = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  drrip_pkg::t_cmd    i_cmd,
    output drrip_pkg::t_status o_status,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_action,
    input  logic [38:0]        i_line_addr,
    input  logic [31:0]        i_payload,
    input  logic [1:0]         i_cpu,
    output logic               o_done,
    output logic               o_hit,
    output logic [31:0]        o_hit_payload,
    output logic               o_evicted_valid,
    output logic [31:0]        o_evicted_tag,
    output logic [31:0]        o_evicted_payload
);
    import drrip_pkg::*;

    localparam int NSETS = 1 << SET_BITS;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CW    = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int SH    = (NSETS >= 256 && NSETS < 1024) ? 4 : ((NSETS >= 64) ? 3 : 2);
    localparam logic [1:0] RRPV_TOP  = 2'd3;
    localparam logic [1:0] RRPV_NEAR = 2'd2;
    localparam logic [9:0] SEL_TOP   = 10'd1023;
    localparam logic [9:0] SEL_MID   = 10'd511;

    typedef logic [WAYS-1:0][TAG_WIDTH-1:0] t_tag_row;
    typedef logic [WAYS-1:0][31:0]          t_pay_row;
    typedef logic [WAYS-1:0][1:0]           t_rrpv_row;

    // Set stores, one row per set
    t_tag_row          mem_tag  [NSETS];
    t_pay_row          mem_pay  [NSETS];
    t_rrpv_row         mem_rrpv [NSETS];
    logic [WW-1:0]     mem_head [NSETS];

    t_tag_row          r_tag_rd;
    t_pay_row          r_pay_rd;
    t_rrpv_row         r_rrpv_rd;
    logic [WW-1:0]     r_head_rd;

    logic [SET_BITS-1:0]  r_clr_idx;
    logic                 r_mode;
    logic                 r_action;
    logic [SET_BITS-1:0]  r_set;
    logic [TAG_WIDTH-1:0] r_tag;
    logic [31:0]          r_pay;
    logic [CW-1:0]        r_core;
    logic [9:0]           r_sel [CORES];
    logic [4:0]           r_bimodal;

    logic [63:0]          addr_sh;
    logic [TAG_WIDTH-1:0] in_tag;
    logic [CW-1:0]        in_core;

    // Extract the tag and clamp the core number
    assign addr_sh = {25'd0, i_line_addr} >> SET_BITS;
    assign in_tag  = addr_sh[TAG_WIDTH-1:0];
    assign in_core = (int'(i_cpu) >= CORES) ? CW'(CORES - 1) : CW'(i_cpu);

    assign o_status.clr_last = (r_clr_idx == SET_BITS'(NSETS - 1));

    // Set update logic
    logic                 hit, has_empty, we;
    logic [WW-1:0]        fidx, eidx, pick, vic;
    logic [1:0]           top, age;
    t_tag_row             n_tag_row;
    t_pay_row             n_pay_row;
    t_rrpv_row            n_rrpv_row;
    logic [WW-1:0]        n_head;
    logic [9:0]           n_sel;
    logic [4:0]           n_bimodal, bim_inc;
    logic [SET_BITS+SH-1:0] set_x;
    logic [SH-1:0]        diff;
    logic                 lead_b, lead_s, use_bim;
    logic [63:0]          vic_tag64;
    logic                 evict;

    always_comb begin
        hit       = 1'b0;
        fidx      = '0;
        has_empty = 1'b0;
        eidx      = '0;
        top       = r_rrpv_rd[0];
        pick      = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!hit && r_tag_rd[w] == r_tag) begin
                hit  = 1'b1;
                fidx = WW'(w);
            end
            if (!has_empty && r_tag_rd[w] == '0) begin
                has_empty = 1'b1;
                eidx      = WW'(w);
            end
            if (r_rrpv_rd[w] > top) begin
                top  = r_rrpv_rd[w];
                pick = WW'(w);
            end
        end
        age = RRPV_TOP - top;
        vic = r_mode ? r_head_rd : (has_empty ? eidx : pick);

        // Duel role of the set
        set_x   = {{SH{1'b0}}, r_set};
        diff    = set_x[SH-1:0] - set_x[2*SH-1:SH];
        lead_b  = (diff == '0);
        lead_s  = (diff == SH'(1));
        bim_inc = r_bimodal + 5'd1;
        use_bim = lead_b || (!lead_s && r_sel[r_core] > SEL_MID);

        n_tag_row  = r_tag_rd;
        n_pay_row  = r_pay_rd;
        n_rrpv_row = r_rrpv_rd;
        n_head     = r_head_rd;
        n_sel      = r_sel[r_core];
        n_bimodal  = r_bimodal;
        we         = 1'b0;
        evict      = 1'b0;

        if (hit) begin
            // Promote on an insert hit when the mode bit is clear
            if (r_action && !r_mode) begin
                n_rrpv_row[fidx] = 2'd0;
                we               = 1'b1;
            end
        end else if (r_action) begin
            we    = 1'b1;
            evict = (r_tag_rd[vic] != '0);
            if (!r_mode && !has_empty) begin
                for (int w = 0; w < WAYS; w++) begin
                    n_rrpv_row[w] = r_rrpv_rd[w] + age;
                end
            end
            n_tag_row[vic] = r_tag;
            n_pay_row[vic] = r_pay;
            if (r_mode) begin
                n_head = (r_head_rd == WW'(WAYS - 1)) ? '0 : r_head_rd + WW'(1);
            end else begin
                if (lead_b && n_sel != 10'd0) begin
                    n_sel = n_sel - 10'd1;
                end else if (lead_s && n_sel != SEL_TOP) begin
                    n_sel = n_sel + 10'd1;
                end
                if (use_bim) begin
                    n_bimodal       = bim_inc;
                    n_rrpv_row[vic] = (bim_inc == 5'd0) ? RRPV_NEAR : RRPV_TOP;
                end else begin
                    n_rrpv_row[vic] = RRPV_NEAR;
                end
            end
        end
        vic_tag64 = 64'(r_tag_rd[vic]);
    end

    // Clear, read and write back the set stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem_tag[r_clr_idx]  <= '0;
            mem_pay[r_clr_idx]  <= '0;
            mem_rrpv[r_clr_idx] <= '0;
            mem_head[r_clr_idx] <= '0;
        end else if (i_cmd.exec && we) begin
            mem_tag[r_set]  <= n_tag_row;
            mem_pay[r_set]  <= n_pay_row;
            mem_rrpv[r_set] <= n_rrpv_row;
            mem_head[r_set] <= n_head;
        end
        if (i_cmd.load) begin
            r_tag_rd  <= mem_tag[i_line_addr[SET_BITS-1:0]];
            r_pay_rd  <= mem_pay[i_line_addr[SET_BITS-1:0]];
            r_rrpv_rd <= mem_rrpv[i_line_addr[SET_BITS-1:0]];
            r_head_rd <= mem_head[i_line_addr[SET_BITS-1:0]];
        end
    end

    // Capture the request word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_set    <= i_line_addr[SET_BITS-1:0];
            r_tag    <= in_tag;
            r_pay    <= i_payload;
            r_core   <= in_core;
        end
    end

    // Register the result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_hit             <= hit;
            o_hit_payload     <= hit ? r_pay_rd[fidx] : 32'd0;
            o_evicted_valid   <= evict;
            o_evicted_tag     <= evict ? vic_tag64[31:0] : 32'd0;
            o_evicted_payload <= evict ? r_pay_rd[vic] : 32'd0;
        end
    end

    // Control state, mode register and duel counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_mode    <= 1'b0;
            o_done    <= 1'b0;
            r_bimodal <= '0;
            for (int c = 0; c < CORES; c++) begin
                r_sel[c] <= '0;
            end
        end else begin
            o_done <= i_cmd.exec;
            if (i_cmd.clr) begin
                r_clr_idx <= r_clr_idx + SET_BITS'(1);
            end
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_bimodal     <= n_bimodal;
                r_sel[r_core] <= n_sel;
            end
        end
    end

`ifndef ASSERT_OFF
    // A result word follows every update and nothing else
    a_done_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_cmd.exec))
        else $error("result word without update");
    // An eviction only comes from a miss
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_evicted_valid |-> !o_hit)
        else $error("eviction reported on a hit");
    // Lookups leave the duel counters alone
    a_lookup_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && !r_action |=> $stable(r_bimodal))
        else $error("lookup changed bimodal counter");
`endif

endmodule

### rtl/core/drrip_set_assoc_tag_cache_core.sv
// A request word accepted while idle is captured with its set row, and the update state
// then writes the row back and registers the result; no new request is taken until then.
// Reset: synchronous active low; afterwards a clearing pass zeros one set row per cycle,
// over all 2**SET_BITS rows with busy high; configuration writes are taken throughout.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Top level of the DRRIP set-associative tag cache core.
module drrip_set_assoc_tag_cache_core #(
    parameter int SET_BITS  = 7,
    parameter int WAYS      = 8,
    parameter int TAG_WIDTH = 32,
    parameter int CORES     = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [38:0] i_line_addr,
    input  logic [31:0] i_payload,
    input  logic [1:0]  i_cpu,
    output logic        o_done,
    output logic        o_hit,
    output logic [31:0] o_hit_payload,
    output logic        o_evicted_valid,
    output logic [31:0] o_evicted_tag,
    output logic [31:0] o_evicted_payload
);
    import drrip_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer
    drrip_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Stores and update logic
    drrip_dp #(
        .SET_BITS  (SET_BITS),
        .WAYS      (WAYS),
        .TAG_WIDTH (TAG_WIDTH),
        .CORES     (CORES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_action          (i_action),
        .i_line_addr       (i_line_addr),
        .i_payload         (i_payload),
        .i_cpu             (i_cpu),
        .o_done            (o_done),
        .o_hit             (o_hit),
        .o_hit_payload     (o_hit_payload),
        .o_evicted_valid   (o_evicted_valid),
        .o_evicted_tag     (o_evicted_tag),
        .o_evicted_payload (o_evicted_payload)
    );

`ifndef ASSERT_OFF
    // An accepted word keeps the block busy for its update
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("not busy after accept");
    // Every result strobe follows an accept
    a_done_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result strobe without accept");
    // Result strobe is never held high
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held");
`endif

endmodule
